// ===== hdl/lsbs_pkg.sv =====
`default_nettype none

package lsbs_pkg;

    typedef enum logic [2:0] {
        MODE_APPEND  = 3'd0,
        MODE_PREPEND = 3'd1,
        MODE_DELETE  = 3'd2,
        MODE_CLEAR   = 3'd3,
        MODE_LSEARCH = 3'd4,
        MODE_BSEARCH = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        STS_DONE  = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2,
        STS_MISS  = 2'd3
    } t_status;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_DECODE   = 11'b000_0000_0010,
        S_PRE_RD   = 11'b000_0000_0100,
        S_PRE_WR   = 11'b000_0000_1000,
        S_SCAN_RD  = 11'b000_0001_0000,
        S_SCAN_CMP = 11'b000_0010_0000,
        S_SHIFT_RD = 11'b000_0100_0000,
        S_SHIFT_WR = 11'b000_1000_0000,
        S_BIN_RD   = 11'b001_0000_0000,
        S_BIN_CMP  = 11'b010_0000_0000,
        S_DONE     = 11'b100_0000_0000
    } t_state;

    typedef enum logic [1:0] {
        RD_IDX    = 2'd0,
        RD_IDX_M1 = 2'd1,
        RD_IDX_P1 = 2'd2,
        RD_MID    = 2'd3
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_TAIL = 2'd0,
        WR_HEAD = 2'd1,
        WR_IDX  = 2'd2
    } t_wr_sel;

    typedef enum logic [2:0] {
        IX_HOLD  = 3'd0,
        IX_ZERO  = 3'd1,
        IX_COUNT = 3'd2,
        IX_INC   = 3'd3,
        IX_DEC   = 3'd4
    } t_idx_op;

    typedef enum logic [1:0] {
        CN_HOLD = 2'd0,
        CN_INC  = 2'd1,
        CN_DEC  = 2'd2,
        CN_CLR  = 2'd3
    } t_cnt_op;

    typedef enum logic [1:0] {
        BN_HOLD = 2'd0,
        BN_INIT = 2'd1,
        BN_LO   = 2'd2,
        BN_HI   = 2'd3
    } t_bin_op;

    typedef struct packed {
        logic    latch;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_en;
        t_wr_sel wr_sel;
        t_idx_op idx_op;
        t_cnt_op cnt_op;
        t_bin_op bin_op;
        logic    set_pos;
        logic    status_wr;
        t_status status;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic [2:0] mode;
        logic       full;
        logic       empty;
        logic       match;
        logic       less;
        logic       bin_open;
        logic       idx_zero;
        logic       idx_last;
        logic       idx_end;
    } t_sts;

endpackage

`default_nettype wire

// ===== hdl/lsbs_dpath.sv =====
`default_nettype none

module lsbs_dpath
    import lsbs_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire logic [2:0]  i_mode,
    input  wire logic [31:0] i_value,
    output t_sts             o_sts,
    output logic [1:0]       o_status,
    output logic             o_found,
    output logic [4:0]       o_position,
    output logic [4:0]       o_length
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [31:0]        r_mem [DEPTH];
    logic signed [31:0] r_rdata;
    logic [2:0]         r_mode;
    logic signed [31:0] r_value;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_idx;
    logic [CW-1:0]      r_lo;
    logic [CW-1:0]      r_hi;
    logic [CW-1:0]      r_mid;
    t_status            r_status;
    logic               r_found;
    logic [4:0]         r_pos;
    logic [1:0]         r_out_status;
    logic               r_out_found;
    logic [4:0]         r_out_pos;
    logic [4:0]         r_out_len;

    logic [CW-1:0]      n_mid;
    logic [CW-1:0]      w_diff;
    logic [CW:0]        w_idx_p1;
    logic [CW-1:0]      w_rd_idx;
    logic [CW-1:0]      w_wr_idx;
    logic [31:0]        w_wdata;

    assign w_diff   = r_hi - r_lo - CW'(1);
    assign n_mid    = r_lo + (w_diff >> 1);
    assign w_idx_p1 = {1'b0, r_idx} + (CW+1)'(1);

    always_comb begin
        case (i_cmd.rd_sel)
            RD_IDX:    w_rd_idx = r_idx;
            RD_IDX_M1: w_rd_idx = r_idx - CW'(1);
            RD_IDX_P1: w_rd_idx = w_idx_p1[CW-1:0];
            RD_MID:    w_rd_idx = n_mid;
            default:   w_rd_idx = r_idx;
        endcase
    end

    always_comb begin
        case (i_cmd.wr_sel)
            WR_TAIL: begin
                w_wr_idx = r_count;
                w_wdata  = r_value;
            end
            WR_HEAD: begin
                w_wr_idx = '0;
                w_wdata  = r_value;
            end
            WR_IDX: begin
                w_wr_idx = r_idx;
                w_wdata  = r_rdata;
            end
            default: begin
                w_wr_idx = r_idx;
                w_wdata  = r_rdata;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[w_wr_idx[AW-1:0]] <= w_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[w_rd_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            case (i_cmd.cnt_op)
                CN_HOLD: r_count <= r_count;
                CN_INC:  r_count <= r_count + CW'(1);
                CN_DEC:  r_count <= r_count - CW'(1);
                CN_CLR:  r_count <= '0;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode  <= i_mode;
            r_value <= i_value;
        end

        case (i_cmd.idx_op)
            IX_HOLD:  r_idx <= r_idx;
            IX_ZERO:  r_idx <= '0;
            IX_COUNT: r_idx <= r_count;
            IX_INC:   r_idx <= w_idx_p1[CW-1:0];
            IX_DEC:   r_idx <= r_idx - CW'(1);
            default:  r_idx <= r_idx;
        endcase

        case (i_cmd.bin_op)
            BN_HOLD: ;
            BN_INIT: begin
                r_lo <= '0;
                r_hi <= r_count;
            end
            BN_LO:   r_lo <= r_mid + CW'(1);
            BN_HI:   r_hi <= r_mid;
            default: ;
        endcase

        if (i_cmd.rd_en && i_cmd.rd_sel == RD_MID) begin
            r_mid <= n_mid;
        end

        if (i_cmd.latch) begin
            r_status <= STS_DONE;
            r_found  <= 1'b0;
            r_pos    <= '0;
        end else begin
            if (i_cmd.status_wr) begin
                r_status <= i_cmd.status;
            end
            if (i_cmd.set_pos) begin
                r_found <= 1'b1;
                r_pos   <= 5'(w_idx_p1);
            end
        end

        if (i_cmd.out_load) begin
            r_out_status <= r_status;
            r_out_found  <= r_found;
            r_out_pos    <= r_pos;
            r_out_len    <= 5'(r_count);
        end
    end

    assign o_sts.mode     = r_mode;
    assign o_sts.full     = (r_count >= DEPTH_C);
    assign o_sts.empty    = (r_count == '0);
    assign o_sts.match    = (r_rdata == r_value);
    assign o_sts.less     = (r_rdata < r_value);
    assign o_sts.bin_open = (r_lo < r_hi);
    assign o_sts.idx_zero = (r_idx == '0);
    assign o_sts.idx_last = (w_idx_p1 >= {1'b0, r_count});
    assign o_sts.idx_end  = (r_idx >= r_count);

    assign o_status   = r_out_status;
    assign o_found    = r_out_found;
    assign o_position = r_out_pos;
    assign o_length   = r_out_len;

endmodule

`default_nettype wire

// ===== hdl/lsbs_ctrl.sv =====
`default_nettype none

module lsbs_ctrl
    import lsbs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '{latch: 1'b0, rd_en: 1'b0, rd_sel: RD_IDX, wr_en: 1'b0,
                        wr_sel: WR_IDX, idx_op: IX_HOLD, cnt_op: CN_HOLD,
                        bin_op: BN_HOLD, set_pos: 1'b0, status_wr: 1'b0,
                        status: STS_DONE, out_load: 1'b0};

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                case (t_mode'(i_sts.mode))
                    MODE_APPEND: begin
                        if (i_sts.full) begin
                            o_cmd.status_wr = 1'b1;
                            o_cmd.status    = STS_FULL;
                        end else begin
                            o_cmd.wr_en  = 1'b1;
                            o_cmd.wr_sel = WR_TAIL;
                            o_cmd.cnt_op = CN_INC;
                        end
                    end
                    MODE_PREPEND: begin
                        if (i_sts.full) begin
                            o_cmd.status_wr = 1'b1;
                            o_cmd.status    = STS_FULL;
                        end else begin
                            o_cmd.idx_op = IX_COUNT;
                            n_state      = S_PRE_RD;
                        end
                    end
                    MODE_DELETE, MODE_LSEARCH: begin
                        if (i_sts.empty) begin
                            o_cmd.status_wr = 1'b1;
                            o_cmd.status    = STS_EMPTY;
                        end else begin
                            o_cmd.idx_op = IX_ZERO;
                            n_state      = S_SCAN_RD;
                        end
                    end
                    MODE_CLEAR: begin
                        if (i_sts.empty) begin
                            o_cmd.status_wr = 1'b1;
                            o_cmd.status    = STS_EMPTY;
                        end
                        o_cmd.cnt_op = CN_CLR;
                    end
                    MODE_BSEARCH: begin
                        if (i_sts.empty) begin
                            o_cmd.status_wr = 1'b1;
                            o_cmd.status    = STS_EMPTY;
                        end else begin
                            o_cmd.bin_op = BN_INIT;
                            n_state      = S_BIN_RD;
                        end
                    end
                    default: ;
                endcase
            end
            S_PRE_RD: begin
                if (i_sts.idx_zero) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = WR_HEAD;
                    o_cmd.cnt_op = CN_INC;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_IDX_M1;
                    n_state      = S_PRE_WR;
                end
            end
            S_PRE_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_IDX;
                o_cmd.idx_op = IX_DEC;
                n_state      = S_PRE_RD;
            end
            S_SCAN_RD: begin
                if (i_sts.idx_end) begin
                    o_cmd.status_wr = 1'b1;
                    o_cmd.status    = STS_MISS;
                    n_state         = S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_IDX;
                    n_state      = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (i_sts.match) begin
                    o_cmd.set_pos = 1'b1;
                    if (t_mode'(i_sts.mode) == MODE_DELETE) begin
                        n_state = S_SHIFT_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    o_cmd.idx_op = IX_INC;
                    n_state      = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: begin
                if (i_sts.idx_last) begin
                    o_cmd.cnt_op = CN_DEC;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_IDX_P1;
                    n_state      = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_IDX;
                o_cmd.idx_op = IX_INC;
                n_state      = S_SHIFT_RD;
            end
            S_BIN_RD: begin
                if (!i_sts.bin_open) begin
                    o_cmd.status_wr = 1'b1;
                    o_cmd.status    = STS_MISS;
                    n_state         = S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_MID;
                    n_state      = S_BIN_CMP;
                end
            end
            S_BIN_CMP: begin
                if (i_sts.match) begin
                    o_cmd.idx_op = IX_ZERO;
                    n_state      = S_SCAN_RD;
                end else if (i_sts.less) begin
                    o_cmd.bin_op = BN_LO;
                    n_state      = S_BIN_RD;
                end else begin
                    o_cmd.bin_op = BN_HI;
                    n_state      = S_BIN_RD;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== hdl/list_store_with_linear_binary_search.sv =====
// Ordered store of up to DEPTH signed 32-bit values with insert, delete, clear,
// linear search and binary search, one item at a time. The entries sit in one
// memory with a registered read port, so every walk step is a read, then a
// compare or a write. Append, clear, rejected inserts, empty-store requests
// and unused modes finish without a walk; prepend moves every entry up one
// place from the tail before writing the head; linear search examines entries
// from the head until a match or the end; delete then moves each entry after
// the match down one place; binary search probes the midpoint until a hit or
// an empty range, then rescans from the head for the first match position on
// a hit. A finished result waits in the output register while the next item
// is taken; while that register stays stalled, the next result holds in its
// last cycle and the input stays stalled. Memory contents are not cleared by
// reset; only entries below the current length are ever read.
`default_nettype none

module list_store_with_linear_binary_search
    import lsbs_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_mode,
    input  wire logic [31:0] i_value,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic             o_found,
    output logic [4:0]       o_position,
    output logic [4:0]       o_length
);

    t_cmd w_cmd;
    t_sts w_sts;

    lsbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    lsbs_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_mode     (i_mode),
        .i_value    (i_value),
        .o_sts      (w_sts),
        .o_status   (o_status),
        .o_found    (o_found),
        .o_position (o_position),
        .o_length   (o_length)
    );

endmodule

`default_nettype wire

// ===== hdl/lsbs_checker.sv =====
`default_nettype none

module lsbs_checker
    import lsbs_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [1:0]  o_status,
    input wire logic        o_found,
    input wire logic [4:0]  o_position,
    input wire logic [4:0]  o_length
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_found) && $stable(o_position) && $stable(o_length))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after an item was taken");

    a_found_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_found == (o_position != 5'd0)))
        else $error("found flag and position disagree");

    a_found_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> o_status == STS_DONE)
        else $error("match reported with error status");

    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == STS_EMPTY |-> o_length == 5'd0)
        else $error("empty status with nonzero length");

endmodule

bind list_store_with_linear_binary_search lsbs_checker u_lsbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_status    (o_status),
    .o_found     (o_found),
    .o_position  (o_position),
    .o_length    (o_length)
);

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import lsbs_pkg::*;

    localparam int LIST_DEPTH = 16;
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_ITEMS = 375;

    typedef struct {
        t_status    status;
        logic       found;
        logic [4:0] position;
        logic [4:0] length;
    } list_result_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] value;
        logic [4:0]  reps;
        logic [31:0] step;
        logic        typed;
        t_status     status;
        logic        found;
        logic [4:0]  position;
        logic [4:0]  length;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  in_mode = '0;
    logic [31:0] in_value = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  out_status;
    logic        out_found;
    logic [4:0]  out_position;
    logic [4:0]  out_length;

    // own copy of the list
    logic [31:0] model_vals [LIST_DEPTH];
    int          model_len = 0;

    list_result_t expected_results [$];
    list_result_t blank_result;

    int idle_pct = 0;
    int stall_pct = 0;
    bit hold_request = 1'b0;
    int hold_left = 0;
    int cycle_count = 0;
    int fail_count = 0;
    int items_sent = 0;
    int ignored_sent = 0;
    int results_checked = 0;
    int hits_seen = 0;
    int full_rejects = 0;

    dir_row_t directed_rows [22] = '{
        '{MODE_BSEARCH, 32'h0000_0000, 5'd1, 32'd0, 1'b1, STS_EMPTY, 1'b0, 5'd0, 5'd0},
        '{MODE_DELETE, 32'h0000_0000, 5'd1, 32'd0, 1'b1, STS_EMPTY, 1'b0, 5'd0, 5'd0},
        '{MODE_CLEAR, 32'h0000_0000, 5'd1, 32'd0, 1'b1, STS_EMPTY, 1'b0, 5'd0, 5'd0},
        '{MODE_SPARE_7, 32'hFFFF_FFFF, 5'd1, 32'd0, 1'b1, STS_DONE, 1'b0, 5'd0, 5'd0},
        '{MODE_APPEND, 32'h8000_0000, 5'd1, 32'd0, 1'b1, STS_DONE, 1'b0, 5'd0, 5'd1},
        '{MODE_APPEND, 32'hFFFF_FC18, 5'd14, 32'd100, 1'b0, STS_DONE, 1'b0, 5'd0, 5'd0},
        '{MODE_APPEND, 32'h7FFF_FFFF, 5'd1, 32'd0, 1'b1, STS_DONE, 1'b0, 5'd0, 5'd16},
        '{MODE_PREPEND, 32'h0000_0000, 5'd1, 32'd0, 1'b1, STS_FULL, 1'b0, 5'd0, 5'd16},
        '{MODE_APPEND, 32'h0000_0001, 5'd1, 32'd0, 1'b1, STS_FULL, 1'b0, 5'd0, 5'd16},
        '{MODE_BSEARCH, 32'h7FFF_FFFF, 5'd1, 32'd0, 1'b1, STS_DONE, 1'b1, 5'd16, 5'd16},
        '{MODE_BSEARCH, 32'h8000_0000, 5'd1, 32'd0, 1'b1, STS_DONE, 1'b1, 5'd1, 5'd16},
        '{MODE_LSEARCH, 32'h0000_0001, 5'd1, 32'd0, 1'b1, STS_MISS, 1'b0, 5'd0, 5'd16},
        '{MODE_DELETE, 32'h7FFF_FFFF, 5'd1, 32'd0, 1'b1, STS_DONE, 1'b1, 5'd16, 5'd15},
        '{MODE_DELETE, 32'h0000_0001, 5'd1, 32'd0, 1'b1, STS_MISS, 1'b0, 5'd0, 5'd15},
        '{MODE_DELETE, 32'h8000_0000, 5'd1, 32'd0, 1'b0, STS_DONE, 1'b0, 5'd0, 5'd0},
        '{MODE_PREPEND, 32'h7FFF_FFFF, 5'd1, 32'd0, 1'b0, STS_DONE, 1'b0, 5'd0, 5'd0},
        '{MODE_BSEARCH, 32'h7FFF_FFFF, 5'd1, 32'd0, 1'b0, STS_DONE, 1'b0, 5'd0, 5'd0},
        '{MODE_APPEND, 32'hFFFF_FE0C, 5'd1, 32'd0, 1'b0, STS_DONE, 1'b0, 5'd0, 5'd0},
        '{MODE_BSEARCH, 32'hFFFF_FE0C, 5'd1, 32'd0, 1'b0, STS_DONE, 1'b0, 5'd0, 5'd0},
        '{MODE_SPARE_6, 32'h5555_5555, 5'd1, 32'd0, 1'b0, STS_DONE, 1'b0, 5'd0, 5'd0},
        '{MODE_CLEAR, 32'h0000_0000, 5'd1, 32'd0, 1'b1, STS_DONE, 1'b0, 5'd0, 5'd0},
        '{MODE_LSEARCH, 32'h0000_0000, 5'd1, 32'd0, 1'b1, STS_EMPTY, 1'b0, 5'd0, 5'd0}
    };

    list_store_with_linear_binary_search #(
        .DEPTH(LIST_DEPTH)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_mode     (in_mode),
        .i_value    (in_value),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_status   (out_status),
        .o_found    (out_found),
        .o_position (out_position),
        .o_length   (out_length)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic list_result_t predict_list_op(input logic [2:0] m, input logic [31:0] v);
        list_result_t r;
        int i, at, lo, hi, mid;
        bit hit;
        r.status = STS_DONE;
        r.found = 1'b0;
        r.position = '0;
        at = 0;
        for (i = model_len - 1; i >= 0; i--) begin
            if (model_vals[i] == v) at = i + 1;
        end
        case (m)
            MODE_APPEND, MODE_PREPEND: begin
                if (model_len >= LIST_DEPTH) begin
                    r.status = STS_FULL;
                end else if (m == MODE_APPEND) begin
                    model_vals[model_len] = v;
                    model_len++;
                end else begin
                    for (i = model_len; i > 0; i--) model_vals[i] = model_vals[i - 1];
                    model_vals[0] = v;
                    model_len++;
                end
            end
            MODE_DELETE: begin
                if (model_len == 0) begin
                    r.status = STS_EMPTY;
                end else if (at == 0) begin
                    r.status = STS_MISS;
                end else begin
                    r.found = 1'b1;
                    r.position = 5'(at);
                    for (i = at - 1; i < model_len - 1; i++) model_vals[i] = model_vals[i + 1];
                    model_len--;
                end
            end
            MODE_CLEAR: begin
                if (model_len == 0) r.status = STS_EMPTY;
                model_len = 0;
            end
            MODE_LSEARCH: begin
                if (model_len == 0) begin
                    r.status = STS_EMPTY;
                end else if (at == 0) begin
                    r.status = STS_MISS;
                end else begin
                    r.found = 1'b1;
                    r.position = 5'(at);
                end
            end
            MODE_BSEARCH: begin
                lo = 0;
                hi = model_len;
                hit = 1'b0;
                while (lo < hi && !hit) begin
                    mid = lo + (hi - lo - 1) / 2;
                    if (model_vals[mid] == v) hit = 1'b1;
                    else if ($signed(model_vals[mid]) < $signed(v)) lo = mid + 1;
                    else hi = mid;
                end
                if (model_len == 0) begin
                    r.status = STS_EMPTY;
                end else if (hit) begin
                    r.found = 1'b1;
                    r.position = 5'(at);
                end else begin
                    r.status = STS_MISS;
                end
            end
            default: begin
            end
        endcase
        r.length = 5'(model_len);
        return r;
    endfunction

    task automatic offer_item(input logic [2:0] m, input logic [31:0] v, input bit typed,
                              input list_result_t typed_res);
        list_result_t want;
        @(negedge clk);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_mode <= m;
        in_value <= v;
        do @(posedge clk); while (in_stall);
        want = predict_list_op(m, v);
        if (typed) want = typed_res;
        expected_results.push_back(want);
        if (m == MODE_SPARE_6 || m == MODE_SPARE_7) ignored_sent++;
        else items_sent++;
        if (want.found) hits_seen++;
        if (want.status == STS_FULL) full_rejects++;
    endtask

    task automatic send_op(input logic [2:0] m, input logic [31:0] v);
        offer_item(m, v, 1'b0, blank_result);
    endtask

    task automatic run_random(input int quota);
        logic [31:0] pool [8];
        logic [31:0] sorted_vals [LIST_DEPTH];
        longint acc;
        int i, j, k, n, kind, spread, pick, start_count;
        for (i = 0; i < 8; i++) pool[i] = $urandom;
        start_count = items_sent;
        while (items_sent - start_count < quota) begin
            kind = $urandom_range(99);
            if (kind < 55) begin
                // ascending contents with random spacing, then searches and deletes
                k = ($urandom_range(3) == 0) ? LIST_DEPTH : $urandom_range(1, LIST_DEPTH);
                case ($urandom_range(2))
                    0: spread = 3;
                    1: spread = 5000;
                    default: spread = 32'h0800_0000;
                endcase
                if (spread > 5000)
                    acc = -64'sd2147483648 + longint'($urandom_range(0, 32'h0FFF_FFFF));
                else
                    acc = longint'($signed($urandom));
                for (j = 0; j < k; j++) begin
                    sorted_vals[j] = acc[31:0];
                    acc += $urandom_range(0, spread);
                    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
                end
                send_op(MODE_CLEAR, $urandom);
                if ($urandom_range(1)) begin
                    for (j = 0; j < k; j++) send_op(MODE_APPEND, sorted_vals[j]);
                end else begin
                    for (j = k - 1; j >= 0; j--) send_op(MODE_PREPEND, sorted_vals[j]);
                end
                if (k == LIST_DEPTH && $urandom_range(1))
                    send_op($urandom_range(1) ? MODE_APPEND : MODE_PREPEND, $urandom);
                // broken order now and then
                if ($urandom_range(99) < 15)
                    send_op($urandom_range(1) ? MODE_APPEND : MODE_PREPEND, $urandom);
                n = $urandom_range(4, 12);
                for (j = 0; j < n; j++) begin
                    pick = $urandom_range(k - 1);
                    case ($urandom_range(9))
                        0, 1, 2, 3, 4: send_op(MODE_BSEARCH, sorted_vals[pick]);
                        5: send_op(MODE_BSEARCH, sorted_vals[pick] + 32'd1);
                        6: send_op(MODE_LSEARCH, sorted_vals[pick]);
                        7: send_op(MODE_BSEARCH, $urandom);
                        8: send_op(MODE_DELETE, sorted_vals[pick]);
                        default: send_op(MODE_LSEARCH, $urandom);
                    endcase
                end
            end else if (kind < 90) begin
                if ($urandom_range(1)) pool[$urandom_range(7)] = $urandom;
                n = $urandom_range(5, 24);
                for (j = 0; j < n; j++) begin
                    pick = $urandom_range(99);
                    acc = ($urandom_range(3) != 0) ? longint'(pool[$urandom_range(7)])
                                                   : longint'($urandom);
                    if (pick < 30) send_op(MODE_APPEND, acc[31:0]);
                    else if (pick < 45) send_op(MODE_PREPEND, acc[31:0]);
                    else if (pick < 65) send_op(MODE_DELETE, acc[31:0]);
                    else if (pick < 68) send_op(MODE_CLEAR, acc[31:0]);
                    else if (pick < 84) send_op(MODE_LSEARCH, acc[31:0]);
                    else send_op(MODE_BSEARCH, acc[31:0]);
                end
            end else begin
                n = $urandom_range(1, 4);
                for (j = 0; j < n; j++)
                    send_op($urandom_range(1) ? MODE_SPARE_6 : MODE_SPARE_7, $urandom);
            end
        end
    endtask

    task automatic check_result();
        list_result_t want;
        if (expected_results.size() == 0) begin
            $error("result with no item pending: status %0d length %0d", out_status, out_length);
            fail_count++;
        end else begin
            want = expected_results.pop_front();
            results_checked++;
            if (out_status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, out_status);
                fail_count++;
            end
            if (out_found !== want.found) begin
                $error("found: expected %0d, got %0d", want.found, out_found);
                fail_count++;
            end
            if (out_position !== want.position) begin
                $error("position: expected %0d, got %0d", want.position, out_position);
                fail_count++;
            end
            if (out_length !== want.length) begin
                $error("length: expected %0d, got %0d", want.length, out_length);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) check_result();
    end

    // receiver stall, with one long hold-off on request
    always @(negedge clk) begin
        if (hold_request) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int r, j;
        dir_row_t row;
        list_result_t row_res;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < $size(directed_rows); r++) begin
            row = directed_rows[r];
            row_res.status = row.status;
            row_res.found = row.found;
            row_res.position = row.position;
            row_res.length = row.length;
            for (j = 0; j < row.reps; j++)
                offer_item(row.mode, row.value + j * row.step, row.typed, row_res);
        end

        // receiver holds off while the sender keeps offering
        hold_request = 1'b1;
        run_random(PHASE_ITEMS);
        idle_pct = 71;
        stall_pct = 0;
        run_random(PHASE_ITEMS);
        idle_pct = 0;
        stall_pct = 71;
        run_random(PHASE_ITEMS);
        idle_pct = 27;
        stall_pct = 27;
        run_random(PHASE_ITEMS);

        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d list items and %0d unused-mode items, %0d results checked",
                 items_sent, ignored_sent, results_checked);
        $display("%0d search or delete hits, %0d rejected inserts, %0d mismatches",
                 hits_seen, full_rejects, fail_count);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/lsbs_pkg.sv
hdl/lsbs_dpath.sv
hdl/lsbs_ctrl.sv
hdl/list_store_with_linear_binary_search.sv
hdl/lsbs_checker.sv
verif/testbench.sv
